[hw/rtl/ctwd_pkg.sv]
// Shared codes and widths of the crank trigger-wheel decoder.
package ctwd_pkg;

   localparam int IV_W      = 16;
   localparam int RATIO_W   = 23;
   localparam int DIVIDEND_W = 36;
   localparam int CSR_IDX_W = 3;

   localparam logic [6:0] PERCENT = 7'd100;

   localparam logic [1:0] OP_CRANK = 2'd0;
   localparam logic [1:0] OP_CAM   = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;

   localparam logic [1:0] MODE_INIT = 2'd0;
   localparam logic [1:0] MODE_KEY  = 2'd1;
   localparam logic [1:0] MODE_GAP  = 2'd2;
   localparam logic [1:0] MODE_SYNC = 2'd3;

   localparam logic [3:0] POS_A2   = 4'd1;
   localparam logic [3:0] POS_B1   = 4'd2;
   localparam logic [3:0] POS_D2   = 4'd7;
   localparam logic [3:0] POS_NONE = 4'd8;

   localparam logic [1:0] PH_NONE = 2'd0;
   localparam logic [1:0] PH_CYL1 = 2'd1;
   localparam logic [1:0] PH_CYL2 = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_MIN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO_MAX = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_OPEN  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CAM_CLOSE = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DIVIDEND  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESCALER = 3'd7;

endpackage

[hw/rtl/ctwd_serial_div.sv]
// Bit-serial restoring divider, one quotient bit per cycle.
module ctwd_serial_div #(
   parameter int NW = 36,
   parameter int DW = 37
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW + 1);

   logic [DW-1:0] rem_ff, rem_in;
   logic [NW-1:0] quo_ff, quo_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic [DW:0]   trial;
   logic [DW:0]   diff;
   logic          fits;

   assign trial = {rem_ff, quo_ff[NW-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift in one quotient bit, keep the restored remainder
         rem_in = fits ? diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[NW-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

[hw/rtl/crank_trigger_wheel_decoder_unit.sv]
// Top level of the crank trigger-wheel decoder with key/gap synchronisation.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   req     | req_valid, req_stall, opcode/edge/intvl  | in
//   rsp     | rsp_valid, rsp_stall, status fields      | out
//   csr     | csr_wr_en, csr_index, csr_data           | in
//
// An item is accepted only while the block is idle. Its result reaches the rsp
// ports through these states: PREP starts both dividers, DIV runs the 36
// bit-serial steps of the rpm divider (the key/gap ratio divider runs alongside
// in 23 steps and finishes first) until it sees both dividers idle, COMMIT
// commits, and OUT presents the result. Reset is synchronous; it restores the
// power-up register values. req_stall is high from acceptance until the result
// has been taken; the result holds on the rsp ports while rsp_stall is high.
module crank_trigger_wheel_decoder_unit #(
   parameter int KEY_BEGIN_RISING = 1,
   parameter int EDGES_PER_RPM    = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_opcode,
   input  logic                           req_edge_rising,
   input  logic [ctwd_pkg::IV_W-1:0]      req_interval,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_sync_mode,
   output logic [3:0]                     rsp_crank_position,
   output logic [1:0]                     rsp_phase,
   output logic [31:0]                    rsp_engine_rpm,
   output logic                           rsp_edge_taken,
   output logic                           rsp_output_trigger,
   output logic                           rsp_sync_lost,
   output logic                           rsp_phase_lost,
   input  logic                           csr_wr_en,
   input  logic [ctwd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ctwd_pkg::DIVIDEND_W-1:0] csr_data
);
   import ctwd_pkg::*;

   localparam int SUM_W  = IV_W + $clog2(EDGES_PER_RPM);
   localparam int CNT_W  = $clog2(EDGES_PER_RPM + 1);
   localparam int RDEN_W = 16 + SUM_W;
   localparam logic KEY_BEGIN = (KEY_BEGIN_RISING != 0);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_PREP   = 3'd1;
   localparam logic [2:0] ST_DIV    = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   // configuration
   logic [15:0] ratio_min_ff, ratio_max_ff, noise_ff, presc_ff;
   logic [7:0]  timeout_ff;
   logic [2:0]  cam_open_ff, cam_close_ff;
   logic [DIVIDEND_W-1:0] dividend_ff;

   // sequencer and captured item
   logic [2:0]      st_ff, st_in;
   logic [1:0]      op_ff;
   logic            rise_ff;
   logic [IV_W-1:0] iv_ff;

   // decoder state
   logic [1:0]       mode_ff, mode_in;
   logic [3:0]       pos_ff, pos_in;
   logic [1:0]       phase_ff, phase_in;
   logic             sense_ff, sense_in;
   logic             armed_ff, armed_in;
   logic             run_ff, run_in;
   logic             camwin_ff, camwin_in;
   logic [IV_W-1:0]  key_ff, key_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [31:0]      rpm_ff, rpm_in;
   logic [7:0]       ovf_ff, ovf_in;

   // result flags
   logic taken_ff, taken_in, trig_ff, trig_in;
   logic slost_ff, slost_in, plost_ff, plost_in;

   // dividers
   logic                  div_start;
   logic                  rdz_ff;
   logic [SUM_W-1:0]      sum_next;
   logic [RDEN_W-1:0]     rpm_den;
   logic [RATIO_W-1:0]    ratio_num;
   logic                  ratio_busy, rpm_busy;
   logic [RATIO_W-1:0]    ratio_q;
   logic [DIVIDEND_W-1:0] rpm_q;
   logic                  ratio_ok;
   logic                  accept;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (st_ff != ST_IDLE);
   assign div_start = (st_ff == ST_PREP);

   // ratio always compares the stored key with this interval as gap
   assign sum_next  = sum_ff + SUM_W'(iv_ff);
   assign rpm_den   = RDEN_W'(presc_ff) * RDEN_W'(sum_next);
   assign ratio_num = RATIO_W'(key_ff) * RATIO_W'(PERCENT);

   ctwd_serial_div #(.NW(RATIO_W), .DW(IV_W)) u_ratio_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (ratio_num),
      .den   (iv_ff),
      .busy  (ratio_busy),
      .quo   (ratio_q)
   );

   ctwd_serial_div #(.NW(DIVIDEND_W), .DW(RDEN_W)) u_rpm_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (dividend_ff),
      .den   (rpm_den),
      .busy  (rpm_busy),
      .quo   (rpm_q)
   );

   assign ratio_ok = (iv_ff != '0)
                  && (ratio_q >= RATIO_W'(ratio_min_ff))
                  && (ratio_q <= RATIO_W'(ratio_max_ff));

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:   if (accept) begin st_in = ST_PREP; end
         ST_PREP:   st_in = ST_DIV;
         ST_DIV:    if (!ratio_busy && !rpm_busy) begin st_in = ST_COMMIT; end
         ST_COMMIT: st_in = ST_OUT;
         ST_OUT:    if (!rsp_stall) begin st_in = ST_IDLE; end
         default:   st_in = ST_IDLE;
      endcase
   end

   // apply one item to the decoder state
   always_comb begin
      logic arm;
      logic [3:0] pos_t;
      logic [1:0] phase_t;
      logic cam_t;
      logic [CNT_W-1:0] cnt_t;

      mode_in  = mode_ff;
      pos_in   = pos_ff;
      phase_in = phase_ff;
      sense_in = sense_ff;
      armed_in = armed_ff;
      run_in   = run_ff;
      camwin_in = camwin_ff;
      key_in   = key_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      rpm_in   = rpm_ff;
      ovf_in   = ovf_ff;
      taken_in = 1'b0;
      trig_in  = 1'b0;
      slost_in = 1'b0;
      plost_in = 1'b0;
      arm      = armed_ff || (run_ff && (iv_ff >= noise_ff));
      pos_t    = pos_ff;
      phase_t  = phase_ff;
      cam_t    = camwin_ff;
      cnt_t    = cnt_ff + 1'b1;

      if (st_ff == ST_COMMIT) begin
         unique case (op_ff)
            OP_CRANK: begin
               armed_in = arm;
               if ((rise_ff == sense_ff) && arm) begin
                  taken_in = 1'b1;
                  unique case (mode_ff)
                     MODE_INIT: begin
                        run_in   = 1'b1;
                        sense_in = !KEY_BEGIN;
                        mode_in  = MODE_KEY;
                        pos_in   = POS_NONE;
                        phase_in = PH_NONE;
                        sum_in   = '0;
                        cnt_in   = '0;
                     end
                     MODE_KEY: begin
                        key_in   = iv_ff;
                        sense_in = KEY_BEGIN;
                        mode_in  = MODE_GAP;
                        pos_in   = POS_NONE;
                     end
                     MODE_GAP: begin
                        sense_in = !KEY_BEGIN;
                        if (ratio_ok) begin
                           mode_in  = MODE_SYNC;
                           pos_in   = POS_B1;
                           phase_in = PH_NONE;
                           sum_in   = '0;
                           cnt_in   = '0;
                           rpm_in   = '0;
                        end else begin
                           mode_in = MODE_KEY;
                           pos_in  = POS_NONE;
                        end
                     end
                     default: begin
                        trig_in  = 1'b1;
                        pos_t    = (pos_ff >= POS_D2) ? 4'd0 : pos_ff + 4'd1;
                        sense_in = !sense_ff;
                        // rpm over the last group of synced edges
                        if (cnt_t >= CNT_W'(EDGES_PER_RPM)) begin
                           if (rdz_ff) begin
                              rpm_in = '0;
                           end else if (|rpm_q[DIVIDEND_W-1:32]) begin
                              rpm_in = '1;
                           end else begin
                              rpm_in = rpm_q[31:0];
                           end
                           sum_in = '0;
                           cnt_in = '0;
                        end else begin
                           sum_in = sum_next;
                           cnt_in = cnt_t;
                        end
                        // recheck the key/gap ratio once per revolution
                        if (pos_t == POS_A2) begin
                           key_in = iv_ff;
                        end else if (pos_t == POS_B1 && !ratio_ok) begin
                           pos_t    = POS_NONE;
                           mode_in  = MODE_KEY;
                           sense_in = KEY_BEGIN;
                           phase_t  = PH_NONE;
                           cam_t    = 1'b0;
                           slost_in = 1'b1;
                        end
                        // cam window; opening wins when both match
                        if (pos_t == {1'b0, cam_open_ff}) begin
                           cam_t = 1'b1;
                        end else if (pos_t == {1'b0, cam_close_ff}) begin
                           cam_t = 1'b0;
                           if (phase_t == PH_CYL1) begin
                              phase_t = PH_CYL2;
                           end else if (phase_t == PH_CYL2) begin
                              phase_t  = PH_NONE;
                              plost_in = 1'b1;
                           end
                        end
                        pos_in    = pos_t;
                        phase_in  = phase_t;
                        camwin_in = cam_t;
                     end
                  endcase
                  ovf_in   = '0;
                  armed_in = 1'b0;
               end
            end
            OP_CAM: begin
               if (camwin_ff) begin
                  if (phase_ff == PH_CYL1) begin
                     phase_in = PH_NONE;
                     plost_in = 1'b1;
                  end else begin
                     phase_in = PH_CYL1;
                  end
                  camwin_in = 1'b0;
               end
            end
            OP_TICK: begin
               if (run_ff) begin
                  armed_in = 1'b1;
                  if (ovf_ff >= timeout_ff) begin
                     // timeout: drop back to init
                     mode_in   = MODE_INIT;
                     pos_in    = POS_NONE;
                     sum_in    = '0;
                     cnt_in    = '0;
                     rpm_in    = '0;
                     trig_in   = 1'b1;
                     run_in    = 1'b0;
                     sense_in  = KEY_BEGIN;
                     camwin_in = 1'b0;
                     phase_in  = PH_NONE;
                  end else if (ovf_ff != 8'hFF) begin
                     ovf_in = ovf_ff + 8'd1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         ratio_min_ff <= 16'd50;
         ratio_max_ff <= 16'd150;
         noise_ff     <= 16'd100;
         timeout_ff   <= 8'd20;
         cam_open_ff  <= 3'd0;
         cam_close_ff <= 3'd4;
         dividend_ff  <= 36'd20160000000;
         presc_ff     <= 16'd1;
         mode_ff      <= MODE_INIT;
         pos_ff       <= POS_NONE;
         phase_ff     <= PH_NONE;
         sense_ff     <= KEY_BEGIN;
         armed_ff     <= 1'b1;
         run_ff       <= 1'b0;
         camwin_ff    <= 1'b0;
         key_ff       <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         rpm_ff       <= '0;
         ovf_ff       <= '0;
         taken_ff     <= 1'b0;
         trig_ff      <= 1'b0;
         slost_ff     <= 1'b0;
         plost_ff     <= 1'b0;
      end else begin
         st_ff     <= st_in;
         mode_ff   <= mode_in;
         pos_ff    <= pos_in;
         phase_ff  <= phase_in;
         sense_ff  <= sense_in;
         armed_ff  <= armed_in;
         run_ff    <= run_in;
         camwin_ff <= camwin_in;
         key_ff    <= key_in;
         sum_ff    <= sum_in;
         cnt_ff    <= cnt_in;
         rpm_ff    <= rpm_in;
         ovf_ff    <= ovf_in;
         if (st_ff == ST_COMMIT) begin
            taken_ff <= taken_in;
            trig_ff  <= trig_in;
            slost_ff <= slost_in;
            plost_ff <= plost_in;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_RATIO_MIN: ratio_min_ff <= csr_data[15:0];
               CSR_RATIO_MAX: ratio_max_ff <= csr_data[15:0];
               CSR_NOISE:     noise_ff     <= csr_data[15:0];
               CSR_TIMEOUT:   timeout_ff   <= csr_data[7:0];
               CSR_CAM_OPEN:  cam_open_ff  <= csr_data[2:0];
               CSR_CAM_CLOSE: cam_close_ff <= csr_data[2:0];
               CSR_DIVIDEND:  dividend_ff  <= csr_data;
               CSR_PRESCALER: presc_ff     <= csr_data[15:0];
               default: begin
               end
            endcase
         end
      end
      if (accept) begin
         op_ff   <= req_opcode;
         rise_ff <= req_edge_rising;
         iv_ff   <= req_interval;
      end
      if (div_start) begin
         rdz_ff <= (rpm_den == '0);
      end
   end

   assign rsp_valid          = (st_ff == ST_OUT);
   assign rsp_sync_mode      = mode_ff;
   assign rsp_crank_position = pos_ff;
   assign rsp_phase          = phase_ff;
   assign rsp_engine_rpm     = rpm_ff;
   assign rsp_edge_taken     = taken_ff;
   assign rsp_output_trigger = trig_ff;
   assign rsp_sync_lost      = slost_ff;
   assign rsp_phase_lost     = plost_ff;

endmodule
